// ----- src/sbpm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbpm_pkg
// Types, constants and the bin-to-band map of the band peak meter.
// ----------------------------------------------------------------------------
package sbpm_pkg;

  localparam int NUM_BANDS = 8;
  localparam int NUM_BINS  = 256;

  localparam int OP_W    = 2;
  localparam int BIN_W   = $clog2(NUM_BINS);
  localparam int MAG_W   = 24;
  localparam int DIV_W   = 16;
  localparam int BAND_W  = $clog2(NUM_BANDS);
  localparam int LEVEL_W = 8;
  localparam int TIME_W  = 32;
  localparam int CNT_W   = $clog2(MAG_W);

  typedef logic [OP_W-1:0]    opcode_t;
  typedef logic [BAND_W-1:0]  band_t;
  typedef logic [LEVEL_W-1:0] level_t;
  typedef logic [DIV_W-1:0]   divisor_t;
  typedef logic [TIME_W-1:0]  stamp_t;

  // Item opcodes
  localparam opcode_t OP_BIN   = 2'd0;
  localparam opcode_t OP_FRAME = 2'd1;
  localparam opcode_t OP_TICK  = 2'd2;

  localparam logic [MAG_W-1:0] NOISE_FLOOR = 24'd1500;
  localparam level_t           LEVEL_MAX   = 8'd200;
  localparam stamp_t           STALE_MS    = 32'd50;
  localparam level_t           LEVEL_DECAY = 8'd4;
  localparam level_t           PEAK_DECAY  = 8'd2;

  localparam divisor_t DIV_RESET [NUM_BANDS] = '{
    16'd500, 16'd200, 16'd200, 16'd200, 16'd200, 16'd100, 16'd100, 16'd50
  };

  // Band lookup result: hit is low for the dropped bin
  typedef struct packed {
    logic  hit;
    band_t band;
  } band_sel_t;

  function automatic band_sel_t bin_to_band(input logic [BIN_W-1:0] bin);
    band_sel_t sel;
    sel.hit = 1'b1;
    if (bin <= 8'd2)        sel.band = 3'd0;
    else if (bin == 8'd3) begin
      sel.hit  = 1'b0;
      sel.band = 3'd0;
    end
    else if (bin <= 8'd5)   sel.band = 3'd1;
    else if (bin <= 8'd7)   sel.band = 3'd2;
    else if (bin <= 8'd15)  sel.band = 3'd3;
    else if (bin <= 8'd30)  sel.band = 3'd4;
    else if (bin <= 8'd53)  sel.band = 3'd5;
    else if (bin <= 8'd200) sel.band = 3'd6;
    else                    sel.band = 3'd7;
    return sel;
  endfunction

  // Subtract with floor at zero
  function automatic level_t sat_sub(input level_t a, input level_t b);
    return (a > b) ? level_t'(a - b) : '0;
  endfunction

endpackage

// ----- src/spectrum_band_peak_meter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spectrum_band_peak_meter
// Eight-band level meter with peak hold, stale-level decay and frame reports.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_stall  | opcode, bin_index, magnitude
//  out     | output    | out_valid / out_stall| band_number, level, peak,
//          |           |                      | last_of_run
//  cfg     | input     | cfg_write            | cfg_index, cfg_data
//
// A bin item over the noise floor goes through accept, 24 steps of a shared
// restoring divider (one quotient bit a step) and a write-back state.
// A frame item sweeps the eight bands through one update path, one band a
// cycle while the output is not stalled. A tick advances the clock.
// Synchronous reset clears all band state, the clock and the output valid,
// and loads the divisors with their defaults. No clearing pass is needed.
// ----------------------------------------------------------------------------
module spectrum_band_peak_meter (
  input  logic                          clk,
  input  logic                          rst,
  // input items
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [sbpm_pkg::OP_W-1:0]     opcode,
  input  logic [sbpm_pkg::BIN_W-1:0]    bin_index,
  input  logic [sbpm_pkg::MAG_W-1:0]    magnitude,
  // result items
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sbpm_pkg::BAND_W-1:0]   band_number,
  output logic [sbpm_pkg::LEVEL_W-1:0]  level,
  output logic [sbpm_pkg::LEVEL_W-1:0]  peak,
  output logic                          last_of_run,
  // configuration
  input  logic                          cfg_write,
  input  logic [sbpm_pkg::BAND_W-1:0]   cfg_index,
  input  logic [sbpm_pkg::DIV_W-1:0]    cfg_data
);
  import sbpm_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_DIV   = 2'd1;
  localparam logic [1:0] ST_WRITE = 2'd2;
  localparam logic [1:0] ST_FRAME = 2'd3;

  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(MAG_W - 1);
  localparam band_t            BAND_LAST = band_t'(NUM_BANDS - 1);

  logic [1:0]       state;
  band_t            band;
  logic [CNT_W-1:0] cnt;
  logic [MAG_W-1:0] dvd;    // dividend in, quotient out
  divisor_t         rem;

  divisor_t divisor    [NUM_BANDS];
  level_t   band_level [NUM_BANDS];
  level_t   band_peak  [NUM_BANDS];
  stamp_t   band_stamp [NUM_BANDS];
  stamp_t   now_ms;

  logic      in_take;
  band_sel_t sel;

  // Divider step
  logic [DIV_W:0] rem_sh;
  logic           q_bit;
  divisor_t       rem_next;

  // Write-back of a quotient
  level_t quo_level;

  // Frame update of one band
  stamp_t age;
  logic   stale;
  level_t lv_new;
  level_t pk_raised;
  level_t pk_new;
  logic   out_free;
  logic   out_load;

  assign in_stall = (state != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign sel      = bin_to_band(bin_index);
  assign out_free = !out_valid || !out_stall;
  assign out_load = (state == ST_FRAME) && out_free;

  // Restoring divide: one quotient bit per cycle
  always_comb begin
    rem_sh   = {rem, dvd[MAG_W-1]};
    q_bit    = (rem_sh >= {1'b0, divisor[band]});
    rem_next = q_bit ? DIV_W'(rem_sh - {1'b0, divisor[band]}) : rem_sh[DIV_W-1:0];
  end

  // Clamp quotient to the bar range
  assign quo_level = (dvd > MAG_W'(LEVEL_MAX)) ? LEVEL_MAX : dvd[LEVEL_W-1:0];

  // Stale decay and peak fall for the band under the frame sweep
  always_comb begin
    age       = now_ms - band_stamp[band];
    stale     = (age > STALE_MS);
    lv_new    = stale ? sat_sub(band_level[band], LEVEL_DECAY) : band_level[band];
    pk_raised = (stale && (lv_new > band_peak[band])) ? lv_new : band_peak[band];
    pk_new    = sat_sub(pk_raised, PEAK_DECAY);
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_BANDS; i++) divisor[i] <= DIV_RESET[i];
    end else if (cfg_write) begin
      divisor[cfg_index] <= cfg_data;
    end
  end

  // Result valid: set on each band report, cleared once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Sequencer, divider and band state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      band      <= '0;
      cnt       <= '0;
      now_ms    <= '0;
      for (int i = 0; i < NUM_BANDS; i++) begin
        band_level[i] <= '0;
        band_peak[i]  <= '0;
        band_stamp[i] <= '0;
      end
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_take) begin
            case (opcode)
              OP_BIN: begin
                if (magnitude > NOISE_FLOOR && sel.hit) begin
                  band  <= sel.band;
                  dvd   <= magnitude;
                  rem   <= '0;
                  cnt   <= '0;
                  state <= ST_DIV;
                end
              end
              OP_FRAME: begin
                band  <= '0;
                state <= ST_FRAME;
              end
              OP_TICK: now_ms <= now_ms + 1'b1;
              default: ;
            endcase
          end
        end

        ST_DIV: begin
          dvd <= {dvd[MAG_W-2:0], q_bit};
          rem <= rem_next;
          cnt <= cnt + 1'b1;
          if (cnt == DIV_LAST) state <= ST_WRITE;
        end

        ST_WRITE: begin
          band_level[band] <= quo_level;
          band_stamp[band] <= now_ms;
          if (quo_level > band_peak[band]) band_peak[band] <= quo_level;
          state <= ST_IDLE;
        end

        ST_FRAME: begin
          if (out_free) begin
            band_level[band] <= lv_new;
            band_peak[band]  <= pk_new;
            if (stale) band_stamp[band] <= now_ms;
            band_number <= band;
            level       <= lv_new;
            peak        <= pk_new;
            last_of_run <= (band == BAND_LAST);
            if (band == BAND_LAST) state <= ST_IDLE;
            else band <= band + 1'b1;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  // Checks
  a_out_from_frame: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_FRAME)
    else $error("result raised outside the frame sweep");

  a_last_is_band7: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_of_run |-> band_number == BAND_LAST)
    else $error("last_of_run on a band other than the last");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> level <= LEVEL_MAX && peak <= LEVEL_MAX)
    else $error("reported level or peak above full scale");

  a_div_to_write: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV && cnt == DIV_LAST |=> state == ST_WRITE)
    else $error("divider did not hand over to write-back");

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the eight-band spectrum peak meter. A scoreboard mirrors the
// band levels, held peaks, age stamps and millisecond clock, and predicts the
// eight band reports of every frame item. Directed items hit the bin edges,
// the noise floor and the staleness boundary. Random phases under several
// divisor settings follow, with random idling on both channels, one long
// output hold-off and pauses that drain all outstanding reports.
// ----------------------------------------------------------------------------
module tb;
  import sbpm_pkg::*;

  typedef logic [BIN_W-1:0] bin_t;
  typedef logic [MAG_W-1:0] mag_t;

  typedef struct packed {
    band_t  band;
    level_t level;
    level_t peak;
    logic   last;
  } band_report_t;

  localparam opcode_t OP_UNUSED     = 2'd3;
  localparam bin_t    GAP_BIN       = 8'd3;     // bin that belongs to no band
  localparam int      SETTLE_CYCLES = 40;       // lets a bin item in flight finish
  localparam int      CYCLE_LIMIT   = 300000;
  localparam int      PHASE_ITEMS   = 40;

  // Highest bin of each band; bins below the first edge above band 0 skip GAP_BIN
  localparam int BAND_TOP [NUM_BANDS] = '{2, 5, 7, 15, 30, 53, 200, 255};
  localparam int EDGE_BINS [16] = '{0, 2, 3, 4, 5, 7, 8, 15, 16, 30, 31, 53, 54,
                                    200, 201, 255};

  // --------------------------------------------------------------------------
  // Scoreboard: band state mirror and queue of band reports still due
  // --------------------------------------------------------------------------
  class band_meter_scoreboard;
    divisor_t     divisor_q [NUM_BANDS];
    level_t       level_q   [NUM_BANDS];
    level_t       peak_q    [NUM_BANDS];
    stamp_t       stamp_q   [NUM_BANDS];
    stamp_t       now_q;
    band_report_t due_reports [$];
    int           errors;

    function new();
      for (int b = 0; b < NUM_BANDS; b++) begin
        divisor_q[b] = DIV_RESET[b];
        level_q[b]   = '0;
        peak_q[b]    = '0;
        stamp_q[b]   = '0;
      end
      now_q  = '0;
      errors = 0;
    endfunction

    // -1 for the gap bin
    function int band_of_bin(bin_t bin);
      if (bin == GAP_BIN) return -1;
      for (int b = 0; b < NUM_BANDS; b++) begin
        if (int'(bin) <= BAND_TOP[b]) return b;
      end
      return -1;
    endfunction

    // Clamp, lift the peak, restamp
    function void hold_level(int b, logic [31:0] value);
      level_t v;
      v = (value > 32'(LEVEL_MAX)) ? LEVEL_MAX : level_t'(value);
      if (v > peak_q[b]) peak_q[b] = v;
      level_q[b] = v;
      stamp_q[b] = now_q;
    endfunction

    function void note_item(opcode_t op, bin_t bin, mag_t mag);
      int           b;
      stamp_t       age;
      band_report_t r;
      case (op)
        OP_BIN: begin
          b = band_of_bin(bin);
          if (mag > NOISE_FLOOR && b >= 0) begin
            // a zero divisor behaves like a divider returning all ones
            if (divisor_q[b] == '0) hold_level(b, 32'(LEVEL_MAX));
            else hold_level(b, 32'(mag) / 32'(divisor_q[b]));
          end
        end
        OP_TICK: now_q = now_q + 32'd1;
        OP_FRAME: begin
          for (int k = 0; k < NUM_BANDS; k++) begin
            age = now_q - stamp_q[k];
            if (age > STALE_MS)
              hold_level(k, (level_q[k] > LEVEL_DECAY) ?
                            32'(level_q[k] - LEVEL_DECAY) : 32'd0);
            peak_q[k] = (peak_q[k] > PEAK_DECAY) ? level_t'(peak_q[k] - PEAK_DECAY)
                                                 : '0;
            r.band  = band_t'(k);
            r.level = level_q[k];
            r.peak  = peak_q[k];
            r.last  = (k == NUM_BANDS - 1);
            due_reports.push_back(r);
          end
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      errors++;
      // keep the log short if the block is badly off
      if (errors <= 100) $display("mismatch at %0t ns: %s", $time, msg);
    endtask

    task check_report(band_t band, level_t lvl, level_t pk, logic last);
      band_report_t want;
      if (due_reports.size() == 0) begin
        report($sformatf("unexpected report band %0d level %0d peak %0d last %0b",
                         band, lvl, pk, last));
      end else begin
        want = due_reports.pop_front();
        if (band !== want.band)
          report($sformatf("band_number %0d, want %0d", band, want.band));
        if (lvl !== want.level)
          report($sformatf("band %0d level %0d, want %0d", want.band, lvl, want.level));
        if (pk !== want.peak)
          report($sformatf("band %0d peak %0d, want %0d", want.band, pk, want.peak));
        if (last !== want.last)
          report($sformatf("band %0d last_of_run %0b, want %0b", want.band, last,
                           want.last));
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Signals and block under test
  // --------------------------------------------------------------------------
  logic     clk       = 1'b0;
  logic     rst       = 1'b1;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  opcode_t  opcode    = OP_BIN;
  bin_t     bin_index = '0;
  mag_t     magnitude = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  band_t    band_number;
  level_t   level;
  level_t   peak;
  logic     last_of_run;
  logic     cfg_write = 1'b0;
  band_t    cfg_index = '0;
  divisor_t cfg_data  = '0;

  band_meter_scoreboard sb;
  divisor_t             cfg_set [NUM_BANDS];
  int                   items_done  = 0;
  int                   rx_hold_req = 0;
  bit                   tx_brisk    = 1'b0;
  int                   cycle_count = 0;

  spectrum_band_peak_meter i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .opcode      (opcode),
    .bin_index   (bin_index),
    .magnitude   (magnitude),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .band_number (band_number),
    .level       (level),
    .peak        (peak),
    .last_of_run (last_of_run),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  // Offer one item after a random gap (none while tx_brisk); returns at the
  // accepting edge with valid still high so a back-to-back item keeps it up.
  task automatic send_item(opcode_t op, bin_t bin, mag_t mag);
    int gap;
    gap = tx_brisk ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    opcode    <= op;
    bin_index <= bin;
    magnitude <= mag;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_item(op, bin, mag);
    if ((op == OP_BIN && mag > NOISE_FLOOR && bin != GAP_BIN) ||
        op == OP_FRAME || op == OP_TICK)
      items_done++;
  endtask

  // Wait for every due report, then let a bin item in flight finish
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.due_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write cfg_set into all eight divisors on consecutive edges
  task automatic write_divisors();
    for (int b = 0; b < NUM_BANDS; b++) begin
      cfg_write <= 1'b1;
      cfg_index <= band_t'(b);
      cfg_data  <= cfg_set[b];
      @(posedge clk);
      sb.divisor_q[b] = cfg_set[b];
    end
    cfg_write <= 1'b0;
  endtask

  function automatic bin_t rand_bin();
    if ($urandom_range(0, 9) < 3) return bin_t'(EDGE_BINS[$urandom_range(0, 15)]);
    return bin_t'($urandom);
  endfunction

  function automatic mag_t rand_mag();
    case ($urandom_range(0, 9))
      0, 1, 2:    return mag_t'($urandom_range(0, 3000));
      3, 4, 5, 6: return mag_t'($urandom_range(1501, 200000));
      default:    return mag_t'($urandom);
    endcase
  endfunction

  task automatic tick_run(int n);
    repeat (n) send_item(OP_TICK, bin_t'($urandom), mag_t'($urandom));
  endtask

  // One random action: a bin, a frame, a run of ticks, or an unused opcode
  task automatic random_action();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50)      send_item(OP_BIN, rand_bin(), rand_mag());
    else if (pick < 62) send_item(OP_FRAME, bin_t'($urandom), mag_t'($urandom));
    else if (pick < 90) tick_run($urandom_range(1, 6));
    else if (pick < 94) tick_run($urandom_range(45, 60));
    else                send_item(OP_UNUSED, bin_t'($urandom), mag_t'($urandom));
  endtask

  // Output held off long while frames keep coming, so the block backs up
  task automatic flood_frames();
    rx_hold_req = 300;
    tx_brisk    = 1'b1;
    repeat (6) send_item(OP_FRAME, bin_t'($urandom), mag_t'($urandom));
    tx_brisk    = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Output side
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int hold;
    int taken;
    bit quiet;
    quiet = 1'b0;
    taken = 0;
    while (rst) @(posedge clk);
    forever begin
      if (rx_hold_req > 0) begin
        hold        = rx_hold_req;
        rx_hold_req = 0;
      end else begin
        hold = quiet ? 0 : $urandom_range(0, 10);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      sb.check_report(band_number, level, peak, last_of_run);
      taken++;
      if (taken % 24 == 0) quiet = ($urandom_range(0, 2) == 0);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int  target;
    bit  pressed;
    sb      = new();
    pressed = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed items, reset divisors
    send_item(OP_FRAME, 8'd0, 24'd0);               // everything still at zero
    send_item(OP_BIN, 8'd0, 24'hFFFFFF);            // full scale, clamps
    send_item(OP_BIN, 8'd2, 24'd1501);              // just over the noise floor
    send_item(OP_BIN, GAP_BIN, 24'hFFFFFF);         // gap bin is dropped
    send_item(OP_BIN, 8'd4, 24'd1500);              // at the floor, dropped
    send_item(OP_BIN, 8'd5, 24'd0);
    send_item(OP_BIN, 8'd7, 24'd40000);
    send_item(OP_BIN, 8'd8, 24'd3000);
    send_item(OP_BIN, 8'd15, 24'd100000);
    send_item(OP_BIN, 8'd16, 24'd5000);
    send_item(OP_BIN, 8'd30, 24'd9999);
    send_item(OP_BIN, 8'd31, 24'd2500);
    send_item(OP_BIN, 8'd53, 24'd16000);
    send_item(OP_BIN, 8'd54, 24'd1600);
    send_item(OP_BIN, 8'd200, 24'd20100);
    send_item(OP_BIN, 8'd201, 24'd1501);
    send_item(OP_BIN, 8'd255, 24'd7777);
    send_item(OP_TICK, 8'hFF, 24'hFFFFFF);
    send_item(OP_UNUSED, 8'hAA, 24'h555555);         // no effect, no report
    send_item(OP_FRAME, 8'h55, 24'hAAAAAA);

    // Staleness boundary, and a decayed level rising above a sagging peak
    drain();
    send_item(OP_BIN, 8'd255, 24'd10000);
    repeat (3) send_item(OP_FRAME, 8'd0, 24'd0);
    tick_run(50);                                   // age exactly 50: fresh
    send_item(OP_FRAME, 8'd0, 24'd0);
    tick_run(1);                                    // age 51: stale
    send_item(OP_FRAME, 8'd0, 24'd0);
    send_item(OP_FRAME, 8'd0, 24'd0);

    // Random phases, each under its own divisor setting
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      for (int b = 0; b < NUM_BANDS; b++) begin
        case (ph)
          0:       cfg_set[b] = 16'd1;
          1:       cfg_set[b] = 16'hFFFF;
          2:       cfg_set[b] = divisor_t'($urandom_range(1, 65535));
          3:       cfg_set[b] = divisor_t'($urandom_range(20, 3000));
          4:       cfg_set[b] = divisor_t'($urandom_range(1, 400));
          default: cfg_set[b] = DIV_RESET[b];
        endcase
      end
      if (ph == 2) cfg_set[$urandom_range(0, NUM_BANDS - 1)] = '0;
      write_divisors();
      tx_brisk = 1'b0;
      target   = items_done + PHASE_ITEMS;
      while (items_done < target) begin
        if ($urandom_range(0, 19) == 0) tx_brisk = !tx_brisk;
        random_action();
        if (ph == 3 && !pressed && items_done > target - 40) begin
          flood_frames();
          pressed = 1'b1;
        end
        if ($urandom_range(0, 39) == 0) drain();
      end
    end

    drain();
    if (sb.errors == 0 && sb.due_reports.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/sbpm_pkg.sv
src/spectrum_band_peak_meter.sv
sim/tb.sv
